[hw/rtl/led_seq_pkg.sv]
// ----------------------------------------------------------------------------
// LED effect sequencer package
// Shared widths, register indexes, effect codes, reset values and result type.
// ----------------------------------------------------------------------------
package led_seq_pkg;

  // Number of LEDs driven by the pattern register
  localparam int unsigned LedCount = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgSpeedDivide   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPressTicks = 2'd1;

  // Configuration reset values
  localparam logic [7:0]  SpeedDivideRst   = 8'd20;
  localparam logic [15:0] LongPressTicksRst = 16'd160;

  // Effect codes
  localparam logic [2:0] EffLeft    = 3'd0;
  localparam logic [2:0] EffRight   = 3'd1;
  localparam logic [2:0] EffJohnson = 3'd2;
  localparam logic [2:0] EffRotate  = 3'd3;
  localparam logic [2:0] EffFill    = 3'd4;

  // Pattern constants
  localparam logic [LedCount-1:0] PatAllOn    = 8'hFF;
  localparam logic [LedCount-1:0] PatRotate   = 8'h0F;
  localparam logic [LedCount-1:0] PatLowBit   = 8'h01;
  localparam logic [LedCount-1:0] PatHighBit  = 8'h80;
  localparam logic [15:0]         HoldMax     = 16'hFFFF;

  // Debounce history patterns
  localparam logic [2:0] PressPat   = 3'b100;
  localparam logic [3:0] ReleasePat = 4'b0011;

  // One result item
  typedef struct packed {
    logic [LedCount-1:0] led_pattern;
    logic [2:0]          effect_index;
    logic                is_halted;
  } result_t;

endpackage

[hw/rtl/led_effect_sequencer_top.sv]
// ----------------------------------------------------------------------------
// LED effect sequencer top level
// Five-effect LED chaser driven by tick items, with debounced stop/next button.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one tick item holding the
//   sampled button level (0 = pressed). Every accepted item updates the
//   effect, debounce and hold state and produces exactly one result item on
//   the output channel (out_valid_o / out_stall_i): LED pattern, active
//   effect and halt flag.
//   A result is written into the result queue when its item is accepted.
//   Throughput is one item per cycle while the queue is not full; the state
//   update is combinational shift/compare/count logic between the state registers.
//   A two-entry result queue sits on the output, so one item is still taken
//   while a result waits under stall; in_stall_o rises only when both entries
//   are occupied.
//   Reset clears the queue and loads the power-up state (chaser at bit 0,
//   effect 0, running) and the register defaults (divide 20, long press 160).
//   Configuration writes apply on the edge where cfg_we_i is high.
// ----------------------------------------------------------------------------
module led_effect_sequencer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [led_seq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [led_seq_pkg::CfgDataW-1:0]   cfg_data_i,
  // tick items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               button_level_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [led_seq_pkg::LedCount-1:0]   led_pattern_o,
  output logic [2:0]                         effect_index_o,
  output logic                               is_halted_o
);

  localparam int unsigned N = led_seq_pkg::LedCount;

  // Configuration registers
  logic [7:0]  speed_divide_q;
  logic [15:0] long_press_ticks_q;

  // Effect and button state
  logic [7:0]   tick_count_q,  tick_count_d;
  logic [N-1:0] chaser_bits_q, chaser_bits_d;
  logic [N-1:0] fill_bits_q,   fill_bits_d;
  logic [N-1:0] fill_mask_q,   fill_mask_d;
  logic         filling_up_q,  filling_up_d;
  logic [2:0]   effect_sel_q,  effect_sel_d;
  logic         halted_q,      halted_d;
  logic         held_q,        held_d;
  logic [15:0]  hold_ticks_q,  hold_ticks_d;
  logic [3:0]   history_q,     history_d;
  logic [N-1:0] led_q,         led_d;

  // Result queue
  led_seq_pkg::result_t head_q, tail_q, res_new;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_stall_o  = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_divide_q     <= led_seq_pkg::SpeedDivideRst;
      long_press_ticks_q <= led_seq_pkg::LongPressTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        led_seq_pkg::CfgSpeedDivide:    speed_divide_q     <= cfg_data_i[7:0];
        led_seq_pkg::CfgLongPressTicks: long_press_ticks_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Compute the next state for one tick
  always_comb begin
    logic [7:0]   tc;
    logic [N-1:0] cb, fb, fm, led;
    logic         fu, hl, hd, due, clr_inv;
    logic [2:0]   sel;
    logic [15:0]  ht;
    logic [3:0]   hist;

    tc  = tick_count_q;
    cb  = chaser_bits_q;
    fb  = fill_bits_q;
    fm  = fill_mask_q;
    fu  = filling_up_q;
    sel = effect_sel_q;
    hl  = halted_q;
    hd  = held_q;
    ht  = hold_ticks_q;
    led = led_q;
    due = 1'b0;
    clr_inv = (effect_sel_q == led_seq_pkg::EffJohnson);

    // Advance the divider and the active effect
    if (!halted_q && (effect_sel_q <= led_seq_pkg::EffFill)) begin
      tc = tick_count_q + 8'd1;
      if (tc > speed_divide_q) begin
        tc  = '0;
        due = 1'b1;
      end
    end

    if (due) begin
      case (effect_sel_q)
        led_seq_pkg::EffLeft: begin
          led = chaser_bits_q;
          cb  = chaser_bits_q << 1;
          if (cb == '0) cb = led_seq_pkg::PatLowBit;
        end
        led_seq_pkg::EffRight: begin
          led = chaser_bits_q;
          cb  = chaser_bits_q >> 1;
          if (cb == '0) cb = led_seq_pkg::PatHighBit;
        end
        led_seq_pkg::EffRotate: begin
          led = fill_bits_q;
          fb  = {fill_bits_q[N-2:0], fill_bits_q[N-1]};
        end
        led_seq_pkg::EffJohnson, led_seq_pkg::EffFill: begin
          led = fill_bits_q;
          if (filling_up_q) begin
            fb = fill_bits_q | fill_mask_q;
            fm = fill_mask_q << 1;
          end else begin
            fb = clr_inv ? (fill_bits_q & ~fill_mask_q) : (fill_bits_q & fill_mask_q);
            fm = (fill_mask_q << 1) | led_seq_pkg::PatLowBit;
          end
          if (fb == led_seq_pkg::PatAllOn) begin
            fu = 1'b0;
          end else if (fb == '0) begin
            fm = led_seq_pkg::PatLowBit;
            fu = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Shift in the button sample and detect press / release
    hist = {history_q[2:0], button_level_i};
    if (hist[2:0] == led_seq_pkg::PressPat) hd = 1'b1;
    if (hist == led_seq_pkg::ReleasePat) begin
      hd = 1'b0;
      if (hold_ticks_q > long_press_ticks_q) begin
        if (halted_q) begin
          sel = (effect_sel_q >= led_seq_pkg::EffFill) ? led_seq_pkg::EffLeft
                                                        : effect_sel_q + 3'd1;
          tc  = '0;
          cb  = '0;
          fb  = (sel == led_seq_pkg::EffRotate) ? led_seq_pkg::PatRotate : '0;
          fu  = 1'b1;
          hl  = 1'b0;
        end
      end else begin
        hl = !halted_q;
      end
      ht = '0;
    end

    // Count hold time, saturating
    if (hd && (ht != led_seq_pkg::HoldMax)) ht = ht + 16'd1;

    tick_count_d  = tc;
    chaser_bits_d = cb;
    fill_bits_d   = fb;
    fill_mask_d   = fm;
    filling_up_d  = fu;
    effect_sel_d  = sel;
    halted_d      = hl;
    held_d        = hd;
    hold_ticks_d  = ht;
    history_d     = hist;
    led_d         = led;

    res_new.led_pattern  = led;
    res_new.effect_index = sel;
    res_new.is_halted    = hl;
  end

  // Update state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q  <= '0;
      chaser_bits_q <= led_seq_pkg::PatLowBit;
      fill_bits_q   <= '0;
      fill_mask_q   <= led_seq_pkg::PatLowBit;
      filling_up_q  <= 1'b1;
      effect_sel_q  <= led_seq_pkg::EffLeft;
      halted_q      <= 1'b0;
      held_q        <= 1'b0;
      hold_ticks_q  <= '0;
      history_q     <= '0;
      led_q         <= '0;
    end else if (push) begin
      tick_count_q  <= tick_count_d;
      chaser_bits_q <= chaser_bits_d;
      fill_bits_q   <= fill_bits_d;
      fill_mask_q   <= fill_mask_d;
      filling_up_q  <= filling_up_d;
      effect_sel_q  <= effect_sel_d;
      halted_q      <= halted_d;
      held_q        <= held_d;
      hold_ticks_q  <= hold_ticks_d;
      history_q     <= history_d;
      led_q         <= led_d;
    end
  end

  // Track result queue occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: ;
      endcase
    end
  end

  // Hold result payloads: head is shown, tail waits behind it
  always_ff @(posedge clk_i) begin
    if (pop) begin
      head_q <= (push || count_q == 2'd2) ? ((count_q == 2'd2) ? tail_q : res_new) : head_q;
    end else if (push && count_q == 2'd0) begin
      head_q <= res_new;
    end
    if (push && !pop && count_q == 2'd1) begin
      tail_q <= res_new;
    end
  end

  assign led_pattern_o  = head_q.led_pattern;
  assign effect_index_o = head_q.effect_index;
  assign is_halted_o    = head_q.is_halted;

endmodule

[hw/rtl/led_seq_checker.sv]
// ----------------------------------------------------------------------------
// LED effect sequencer port checker
// Port-level assertions on the sequencer's channels, bound to the top level.
// ----------------------------------------------------------------------------
module led_seq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] led_pattern_o,
  input logic [2:0] effect_index_o,
  input logic       is_halted_o
);

  // Keep a stalled result item in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result item dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(led_pattern_o) && $stable(effect_index_o) && $stable(is_halted_o))
    else $error("stalled result item changed");

  // Stall input only while a result item is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_valid_o))
    else $error("input stalled without pending results");

  // Produce no result item without an accepted tick item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result item invented");

  // Report only existing effects
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> effect_index_o <= 3'd4)
    else $error("effect index out of range");

endmodule

bind led_effect_sequencer_top led_seq_checker u_led_seq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .led_pattern_o  (led_pattern_o),
  .effect_index_o (effect_index_o),
  .is_halted_o    (is_halted_o)
);
